### rtl/core/shs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values and the small SHA-256 bit functions.
// ----------------------------------------------------------------------------
package shs_pkg;

	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned LEN_POS     = 56;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef logic [7:0][31:0] hash_words_t;

	// Word 0 sits in the lowest slot.
	localparam hash_words_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

### rtl/core/shs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher channels
// Message byte channel and digest channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface shs_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       is_last;

	modport source (output valid, data_byte, byte_valid, is_last, input ready);
	modport sink   (input valid, data_byte, byte_valid, is_last, output ready);
endinterface

interface shs_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_w0;
	logic [31:0] digest_w1;
	logic [31:0] digest_w2;
	logic [31:0] digest_w3;
	logic [31:0] digest_w4;
	logic [31:0] digest_w5;
	logic [31:0] digest_w6;
	logic [31:0] digest_w7;

	modport source (output valid, digest_w0, digest_w1, digest_w2, digest_w3,
		digest_w4, digest_w5, digest_w6, digest_w7, input ready);
	modport sink   (input valid, digest_w0, digest_w1, digest_w2, digest_w3,
		digest_w4, digest_w5, digest_w6, digest_w7, output ready);
endinterface

### rtl/core/shs_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round on the working variables a..h.
// ----------------------------------------------------------------------------
module shs_round import shs_pkg::*; (
	input  hash_words_t vars,
	input  logic [31:0] k,
	input  logic [31:0] w,
	output hash_words_t vars_next
);

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1  = vars[7] + big_sigma1(vars[4]) + ch + k + w;
		t2  = big_sigma0(vars[0]) + maj;

		vars_next[0] = t1 + t2;
		vars_next[1] = vars[0];
		vars_next[2] = vars[1];
		vars_next[3] = vars[2];
		vars_next[4] = vars[3] + t1;
		vars_next[5] = vars[4];
		vars_next[6] = vars[5];
		vars_next[7] = vars[6];
	end

endmodule

### rtl/core/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream with SHA-256 and returns the eight digest words.
// ----------------------------------------------------------------------------
// Each accepted item may add one byte to the message.
// When a 64-byte block is complete the block drops ready and runs the
// compression with one shared round unit, one round per cycle, then adds
// the result into the chaining value. An item with is_last set starts
// padding, which feeds one byte per cycle (the 0x80 marker, zeros and the
// big-endian bit length) through the same block path, and may run one
// extra block when eight or fewer bytes remain. The digest then moves to
// an output register once that register is free and sits there until it
// is taken; the hasher is ready for the next message as soon as the digest
// is in that register, so a new message may be loaded while the previous
// digest still waits.
module sha256_stream_hasher import shs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	shs_msg_if.sink            msg,
	shs_digest_if.source       digest
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_DONE
	} state_t;

	state_t state_q;

	// Message schedule window: w_q[15] is the oldest word, W[t] during a round.
	// Bytes shift in at the bottom, so the first byte of a block ends up in
	// the top of the oldest word once sixty-four have arrived.
	logic [15:0][31:0] w_q;
	hash_words_t       h_q;         // chaining value
	hash_words_t       v_q;         // working variables a..h
	hash_words_t       v_next;
	hash_words_t       out_q;
	logic              out_valid_q;
	logic [5:0]        fill_q;
	logic [5:0]        rnd_q;
	logic [63:0]       bits_q;
	logic              pad_q;       // message has ended, padding in progress
	logic              first_q;     // next padding byte is the 0x80 marker
	logic              len_ok_q;    // current block carries the length field
	logic              final_q;     // compression under way is the last one

	logic [31:0] w_new;
	logic [7:0]  pad_byte;
	logic [2:0]  len_idx;

	shs_round u_round (
		.vars      (v_q),
		.k         (ROUND_K[rnd_q]),
		.w         (w_q[15]),
		.vars_next (v_next)
	);

	always_comb begin
		w_new   = small_sigma1(w_q[1]) + w_q[6] + small_sigma0(w_q[14]) + w_q[15];
		len_idx = 3'd7 - fill_q[2:0];
		if (first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ok_q && (fill_q >= 6'(LEN_POS))) begin
			pad_byte = bits_q[{len_idx, 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign msg.ready = (state_q == ST_IDLE);

	assign digest.valid     = out_valid_q;
	assign digest.digest_w0 = out_q[0];
	assign digest.digest_w1 = out_q[1];
	assign digest.digest_w2 = out_q[2];
	assign digest.digest_w3 = out_q[3];
	assign digest.digest_w4 = out_q[4];
	assign digest.digest_w5 = out_q[5];
	assign digest.digest_w6 = out_q[6];
	assign digest.digest_w7 = out_q[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= INIT_HASH;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
			rnd_q       <= '0;
			bits_q      <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			// In ST_DONE a taken digest is replaced by the new one below.
			if (digest.valid && digest.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (msg.valid) begin
						pad_q   <= msg.is_last;
						first_q <= msg.is_last;
						if (msg.byte_valid) begin
							w_q    <= {w_q[15][23:0], w_q[14:0], msg.data_byte};
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (msg.byte_valid && (fill_q == 6'(BLOCK_BYTES - 1))) begin
							v_q     <= h_q;
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (msg.is_last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					w_q     <= {w_q[15][23:0], w_q[14:0], pad_byte};
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					if (first_q && (fill_q < 6'(LEN_POS))) begin
						len_ok_q <= 1'b1;
					end
					if (fill_q == 6'(BLOCK_BYTES - 1)) begin
						final_q <= len_ok_q;
						v_q     <= h_q;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					v_q   <= v_next;
					w_q   <= {w_q[14:0], w_new};
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					// An extra block after the marker leaves room for the length.
					if (pad_q && !first_q) begin
						len_ok_q <= 1'b1;
					end
					if (final_q) begin
						state_q <= ST_DONE;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || digest.ready) begin
						out_q       <= h_q;
						out_valid_q <= 1'b1;
						h_q         <= INIT_HASH;
						fill_q      <= '0;
						bits_q      <= '0;
						pad_q       <= 1'b0;
						first_q     <= 1'b0;
						len_ok_q    <= 1'b0;
						final_q     <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// A digest only appears straight out of the final compression.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("digest raised without a finished message");

	// The last round always hands over to the chaining update.
	a_round_to_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'(ROUNDS - 1)) |=> (state_q == ST_FOLD))
		else $error("compression did not end after the last round");

	// Once a digest is issued the message state is back at its start.
	a_clean_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=>
		(fill_q == '0 && bits_q == '0 && !pad_q && h_q == INIT_HASH))
		else $error("message state not cleared after digest");
`endif

endmodule
